@@ rtl/int_stack_machine_execute_top_macros.svh @@
// Assertion macros used by the stack machine controller RTL.
`ifndef INT_STACK_MACHINE_EXECUTE_TOP_MACROS_SVH
`define INT_STACK_MACHINE_EXECUTE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ISM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ISM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/ism_pkg.sv @@
`default_nettype none
package ism_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int REG_COUNT_DEF = 256;
  localparam int WORD_W = 32;

  localparam logic [4:0] OP_LOAD  = 5'd0;
  localparam logic [4:0] OP_READ  = 5'd1;
  localparam logic [4:0] OP_STORE = 5'd2;
  localparam logic [4:0] OP_ADD   = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_MUL   = 5'd5;
  localparam logic [4:0] OP_DIV   = 5'd6;
  localparam logic [4:0] OP_MOD   = 5'd7;
  localparam logic [4:0] OP_JMP   = 5'd8;
  localparam logic [4:0] OP_JZ    = 5'd9;
  localparam logic [4:0] OP_JT    = 5'd10;
  localparam logic [4:0] OP_EQ    = 5'd11;
  localparam logic [4:0] OP_NEQ   = 5'd12;
  localparam logic [4:0] OP_GT    = 5'd13;
  localparam logic [4:0] OP_LT    = 5'd14;
  localparam logic [4:0] OP_GTE   = 5'd15;
  localparam logic [4:0] OP_LTE   = 5'd16;
  localparam logic [4:0] OP_PRINT = 5'd17;
  localparam logic [4:0] OP_INPUT = 5'd18;
  localparam logic [4:0] OP_HALT  = 5'd19;
  localparam logic [4:0] OP_LIMIT = 5'd20;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_UNDER  = 3'd1;
  localparam logic [2:0] ERR_OVER   = 3'd2;
  localparam logic [2:0] ERR_DIVZ   = 3'd3;
  localparam logic [2:0] ERR_BADOP  = 3'd4;
  localparam logic [2:0] ERR_HALTED = 3'd5;

  localparam logic [31:0] ADV_IMM = 32'd4;
  localparam logic [31:0] ADV_REG = 32'd1;

  typedef struct packed {
    logic [4:0]  opcode;
    logic signed [31:0] immediate;
    logic [7:0]  reg_index;
    logic signed [31:0] input_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pc_advance;
    logic        print_valid;
    logic signed [31:0] print_value;
    logic        halted;
    logic [2:0]  error_code;
  } out_item_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic latch_in;     // capture the instruction
    logic rd_top;       // read stack entry at sp-1 and pop
    logic ld_b;         // read data into operand b
    logic ld_a;         // read data into operand a
    logic rd_reg;       // clear result register before a register read
    logic push_val;     // push result/value register
    logic wr_reg;       // write b into register file
    logic alu;          // compute result from a and b, or take register read data
    logic div_start;    // start divider
    logic set_halt;
  } dp_cmd_t;

  typedef struct packed {
    logic       sp_empty;
    logic       sp_full;
    logic       b_zero;
    logic       div_busy;
    logic       halt;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/ism_if.sv @@
`default_nettype none
interface ism_in_if;
  logic valid;
  logic ready;
  ism_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ism_out_if;
  logic valid;
  logic ready;
  ism_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/int_stack_machine_execute_top.sv @@
// Unconditional jumps, halt, load, input and early errors finish straight from
// decode; pops, register access and most operators pass through further states,
// and div and mod wait on the bit-serial divider.
// One instruction at a time: the next request is taken once the result leaves,
// so a div or mod occupies the block for the whole divider run.
// Reset (rst_n, synchronous, active low) empties the stack, clears the halt
// flag and invalidates the register file, whose entries then read as zero.
`default_nettype none
module int_stack_machine_execute_top #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT = ism_pkg::REG_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ism_in_if.sink    in_ch,
  ism_out_if.source out_ch
);
  import ism_pkg::*;

  // The controller sequences one instruction; the datapath owns the stack,
  // register file and divider and only follows commands.
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  in_item_t ins;
  logic [31:0] b_v;

  ism_datapath #(.STACK_DEPTH(STACK_DEPTH), .REG_COUNT(REG_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .b_o(b_v), .ins_o(ins)
  );

  // The result register holds the finished result; a new request is taken in
  // the cycle that result is accepted or once the output side is empty.
  ism_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cmd(cmd), .sts(sts), .b_i(b_v), .ins_i(ins)
  );
endmodule
`default_nettype wire

@@ rtl/ism_ram.sv @@
`default_nettype none
module ism_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/ism_div.sv @@
`default_nettype none
// Signed truncating divider, one quotient bit per cycle.
module ism_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             busy,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);
  logic [31:0] q_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic        nq_r, nr_r;
  logic [32:0] trial;
  logic [31:0] rsh;

  assign rsh = {r_r[30:0], q_r[31]};
  assign trial = {1'b0, rsh} - {1'b0, d_r};
  assign busy = (cnt_r != 6'd0);
  assign quot = nq_r ? (32'd0 - q_r) : q_r;
  assign rem = nr_r ? (32'd0 - r_r) : r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd32;
      q_r <= a[31] ? (32'd0 - a) : a;
      d_r <= b[31] ? (32'd0 - b) : b;
      r_r <= 32'd0;
      nq_r <= a[31] ^ b[31];
      nr_r <= a[31];
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
      if (!trial[32]) begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= rsh;
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/ism_datapath.sv @@
`default_nettype none
module ism_datapath #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT = ism_pkg::REG_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ism_pkg::in_item_t in_data,
  input  wire ism_pkg::dp_cmd_t  cmd,
  output ism_pkg::dp_sts_t       sts,
  output logic [31:0]            b_o,
  output ism_pkg::in_item_t      ins_o
);
  import ism_pkg::*;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  in_item_t    ins_r;
  logic [SPW-1:0] sp_r;
  logic [31:0] a_r, b_r, res_r, prod_r;
  logic [31:0] srd, rrd, qv, rv;
  logic [REG_COUNT-1:0] rvalid_r;
  logic        reg_ok, reg_ok_r, rv_r, busy;
  logic        halt_r;
  logic        lt_ab, lt_ba;
  logic [SAW-1:0] top_addr;

  assign reg_ok = ({24'd0, ins_r.reg_index} < 32'(REG_COUNT));
  assign top_addr = SAW'(sp_r - SPW'(1));
  assign lt_ab = $signed(a_r) < $signed(b_r);
  assign lt_ba = $signed(b_r) < $signed(a_r);

  ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(cmd.push_val), .waddr(SAW'(sp_r)), .wdata(res_r),
    .raddr(top_addr), .rdata(srd)
  );
  ism_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
    .clk(clk), .we(cmd.wr_reg && reg_ok), .waddr(RAW'(ins_r.reg_index)), .wdata(b_r),
    .raddr(RAW'(ins_r.reg_index)), .rdata(rrd)
  );
  ism_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .a(a_r), .b(b_r),
    .busy(busy), .quot(qv), .rem(rv)
  );

  always_ff @(posedge clk) begin
    prod_r <= a_r * b_r;
    if (cmd.latch_in) begin
      ins_r <= in_data;
    end
    if (cmd.ld_b) b_r <= srd;
    if (cmd.ld_a) a_r <= srd;
    reg_ok_r <= reg_ok;
    rv_r <= rvalid_r[RAW'(ins_r.reg_index)];
    if (cmd.latch_in) begin
      res_r <= (in_data.opcode == OP_INPUT) ? in_data.input_value : in_data.immediate;
    end else if (cmd.rd_reg) begin
      res_r <= 32'd0;
    end else if (cmd.alu) begin
      case (ins_r.opcode)
        OP_ADD: res_r <= a_r + b_r;
        OP_SUB: res_r <= a_r - b_r;
        OP_MUL: res_r <= prod_r;
        OP_DIV: res_r <= qv;
        OP_MOD: res_r <= rv;
        OP_EQ:  res_r <= {31'd0, a_r == b_r};
        OP_NEQ: res_r <= {31'd0, a_r != b_r};
        OP_GT:  res_r <= {31'd0, lt_ba};
        OP_LT:  res_r <= {31'd0, lt_ab};
        OP_GTE: res_r <= {31'd0, !lt_ab};
        OP_LTE: res_r <= {31'd0, !lt_ba};
        OP_READ: res_r <= (reg_ok_r && rv_r) ? rrd : 32'd0;
        default: res_r <= res_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      rvalid_r <= '0;
      halt_r <= 1'b0;
    end else begin
      if (cmd.rd_top) sp_r <= sp_r - SPW'(1);
      else if (cmd.push_val) sp_r <= sp_r + SPW'(1);
      if (cmd.wr_reg && reg_ok) rvalid_r[RAW'(ins_r.reg_index)] <= 1'b1;
      if (cmd.set_halt) halt_r <= 1'b1;
    end
  end

  assign sts.halt = halt_r;
  assign sts.sp_empty = (sp_r == '0);
  assign sts.sp_full = (sp_r == SPW'(STACK_DEPTH));
  assign sts.b_zero = (b_r == 32'd0);
  assign sts.div_busy = busy;
  assign b_o = b_r;
  assign ins_o = ins_r;
endmodule
`default_nettype wire

@@ rtl/ism_ctrl.sv @@
`default_nettype none
`include "int_stack_machine_execute_top_macros.svh"
module ism_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ism_pkg::out_item_t   out_data,
  output ism_pkg::dp_cmd_t     cmd,
  input  wire ism_pkg::dp_sts_t sts,
  input  wire logic [31:0]     b_i,
  input  wire ism_pkg::in_item_t ins_i
);
  import ism_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_POPB, S_LDB, S_POPA, S_LDA, S_EXEC, S_MULW,
    S_DIVW, S_ALU, S_PUSH, S_REGR, S_REGW, S_DONE
  } state_t;
  state_t state_r, state_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic is_bin;
  logic [4:0] op;

  assign op = ins_i.opcode;
  assign is_bin = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV)
               || (op == OP_MOD) || (op == OP_EQ) || (op == OP_NEQ) || (op == OP_GT)
               || (op == OP_LT) || (op == OP_GTE) || (op == OP_LTE);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_nxt = '0;
        res_nxt.halted = sts.halt;
        state_nxt = S_DONE;
        if (sts.halt) begin
          res_nxt.error_code = ERR_HALTED;
        end else if (op >= OP_LIMIT) begin
          res_nxt.error_code = ERR_BADOP;
        end else if (op == OP_LOAD || op == OP_INPUT) begin
          if (sts.sp_full) res_nxt.error_code = ERR_OVER;
          else begin
            cmd.push_val = 1'b1;
            res_nxt.pc_advance = (op == OP_LOAD) ? ADV_IMM : 32'd0;
          end
        end else if (op == OP_READ) begin
          if (sts.sp_full) res_nxt.error_code = ERR_OVER;
          else state_nxt = S_REGR;
        end else if (op == OP_JMP) begin
          res_nxt.pc_advance = ins_i.immediate;
        end else if (op == OP_HALT) begin
          cmd.set_halt = 1'b1;
          res_nxt.halted = 1'b1;
        end else if (sts.sp_empty) begin
          res_nxt.error_code = ERR_UNDER;
        end else begin
          cmd.rd_top = 1'b1;
          state_nxt = S_LDB;
        end
      end
      S_LDB: begin
        cmd.ld_b = 1'b1;
        state_nxt = is_bin ? S_POPA : S_EXEC;
      end
      S_POPA: begin
        if (sts.sp_empty) begin
          res_nxt.error_code = ERR_UNDER;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_top = 1'b1;
          state_nxt = S_LDA;
        end
      end
      S_LDA: begin
        cmd.ld_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (op == OP_STORE) begin
          cmd.wr_reg = 1'b1;
          res_nxt.pc_advance = ADV_REG;
        end else if (op == OP_JZ || op == OP_JT) begin
          res_nxt.pc_advance = ((op == OP_JZ) == sts.b_zero) ? ins_i.immediate : ADV_IMM;
        end else if (op == OP_PRINT) begin
          res_nxt.print_valid = 1'b1;
          res_nxt.print_value = b_i;
        end else if ((op == OP_DIV || op == OP_MOD) && sts.b_zero) begin
          res_nxt.error_code = ERR_DIVZ;
        end else if (op == OP_DIV || op == OP_MOD) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIVW;
        end else begin
          state_nxt = S_MULW;
        end
      end
      S_MULW: begin
        cmd.alu = 1'b1;
        state_nxt = S_PUSH;
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          cmd.alu = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_REGR: begin
        cmd.rd_reg = 1'b1;
        state_nxt = S_REGW;
      end
      S_REGW: begin
        cmd.alu = 1'b1;
        res_nxt.pc_advance = ADV_REG;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_val = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
  end

  `ISM_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")
  `ISM_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE, out_valid_r, "result not shown")
  `ISM_ASSERT_IMPL(a_one_op, clk, rst_n, cmd.rd_top, !cmd.push_val, "pop and push together")
  `ISM_ASSERT_IMPL(a_err_quiet, clk, rst_n, out_valid_r && res_r.error_code != ERR_OK,
    res_r.pc_advance == 32'd0 && !res_r.print_valid, "error result carries data")
endmodule
`default_nettype wire
